FILE: hdl/assert_macros.svh
// assertion macros shared by the pose transform rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, held off during reset
`define PPT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, clocked on clk, held off during reset
`define PPT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PPT_ASSERT_IMP(label, ante, cons, msg)
`define PPT_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

FILE: hdl/ppt_pkg.sv
// shared widths, constants, payload type and arctangent table of the pose transform
package ppt_pkg;

	localparam int CORDIC_STEPS = 18;
	localparam int TABLE_LEN    = 24;
	localparam int NUM_ITER     = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

	localparam int POS_W   = 32;
	localparam int HEAD_W  = 22;
	localparam int VEC_W   = POS_W + 1;
	localparam int ANG_W   = HEAD_W + 1;
	localparam int RAW_W   = 38;
	localparam int ZW      = 33;
	localparam int CW      = 43;
	localparam int GUARD   = 8;
	localparam int STEP_W  = 5;
	// heading differences reach about ten turns either way
	localparam int K_W     = 5;
	localparam int GAIN_W  = 31;
	localparam int PROD_W  = VEC_W + GAIN_W;
	localparam int PRESHIFT = 30 - GUARD;
	localparam int ANG_SHIFT = 14;

	// turn count estimate: round(a / 2pi) with a in q.16, via 41 / 2^24
	localparam int K_SHIFT = 24;
	localparam int KP_W    = ANG_W + 7;
	localparam logic signed [6:0]      K_MUL   = 7'sd41;
	localparam logic signed [KP_W-1:0] K_ROUND = KP_W'(1) <<< (K_SHIFT - 1);

	localparam int S_TDATA_W = 176;
	localparam int M_TDATA_W = 88;
	localparam int M_PAD_W   = M_TDATA_W - 2 * POS_W - HEAD_W;

	localparam logic signed [RAW_W-1:0]  PI_RAW     = 38'sd3373259426;
	localparam logic signed [RAW_W-1:0]  TWO_PI_RAW = 38'sd6746518852;
	localparam logic signed [ZW-1:0]     PI_Z       = 33'sd3373259426;
	localparam logic signed [ZW-1:0]     HALF_PI_Z  = 33'sd1686629713;
	localparam logic signed [ZW-1:0]     HEAD_RND   = 33'sd8192;
	localparam logic signed [GAIN_W-1:0] GAIN_Q30   = 31'sd652032874;

	localparam logic signed [POS_W-1:0]  POS_MAX  = 32'sh7fffffff;
	localparam logic signed [POS_W-1:0]  POS_MIN  = -32'sh7fffffff - 32'sd1;
	localparam logic signed [HEAD_W-1:0] HEAD_MAX = 22'sh1fffff;
	localparam logic signed [HEAD_W-1:0] HEAD_MIN = -22'sh1fffff - 22'sd1;
	localparam logic signed [HEAD_W-1:0] HEAD_REL_MAX = 22'sd205887;

	typedef logic [STEP_W-1:0] step_t;

	// rotator payload handed along the cell row
	typedef struct packed {
		logic signed [CW-1:0]     cx;
		logic signed [CW-1:0]     cy;
		logic signed [ZW-1:0]     z;
		logic signed [POS_W-1:0]  ref_x;
		logic signed [POS_W-1:0]  ref_y;
		logic signed [HEAD_W-1:0] heading;
	} ppt_rot_t;

	// atan(2^-i) in q.30, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_q30(input step_t step);
		case (step)
			5'd0:  atan_q30 = 33'sd843314857;
			5'd1:  atan_q30 = 33'sd497837829;
			5'd2:  atan_q30 = 33'sd263043837;
			5'd3:  atan_q30 = 33'sd133525159;
			5'd4:  atan_q30 = 33'sd67021687;
			5'd5:  atan_q30 = 33'sd33543516;
			5'd6:  atan_q30 = 33'sd16775851;
			5'd7:  atan_q30 = 33'sd8388437;
			5'd8:  atan_q30 = 33'sd4194283;
			5'd9:  atan_q30 = 33'sd2097149;
			5'd10: atan_q30 = 33'sd1048576;
			5'd11: atan_q30 = 33'sd524288;
			5'd12: atan_q30 = 33'sd262144;
			5'd13: atan_q30 = 33'sd131072;
			5'd14: atan_q30 = 33'sd65536;
			5'd15: atan_q30 = 33'sd32768;
			5'd16: atan_q30 = 33'sd16384;
			5'd17: atan_q30 = 33'sd8192;
			5'd18: atan_q30 = 33'sd4096;
			5'd19: atan_q30 = 33'sd2048;
			5'd20: atan_q30 = 33'sd1024;
			5'd21: atan_q30 = 33'sd512;
			5'd22: atan_q30 = 33'sd256;
			5'd23: atan_q30 = 33'sd128;
			default: atan_q30 = '0;
		endcase
	endfunction

endpackage

FILE: hdl/planar_pose_transform.sv
// top level of the planar pose compose / relative transform
//
//  channel  dir  tdata (low bit up)                               tuser
//  s_axis   in   ref_x, ref_y, ref_heading, pose_x, pose_y,      command
//                pose_heading, 4 zero bits
//  m_axis   out  out_x, out_y, out_heading, 2 zero bits           -
//
// one transaction in and one out per cycle at full flow
// the path is 5 front stages, CORDIC_STEPS rotation cells (capped at 24) and 1
// output stage, with 18 rotation cells at the default 18 steps
// every stage has its own valid bit and takes a new transaction when empty or
// when its successor moves, so bubbles close up behind a stalled output
// arst_n clears the valid bits only; no clearing pass, ready after reset
module planar_pose_transform (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// ref_x, ref_y, ref_heading, pose_x, pose_y, pose_heading, zero pad
	input  logic [ppt_pkg::S_TDATA_W-1:0]     s_tdata,
	// command
	input  logic [0:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_x, out_y, out_heading, zero pad
	output logic [ppt_pkg::M_TDATA_W-1:0]     m_tdata
);

	localparam int NI = ppt_pkg::NUM_ITER;

	// unpacked input fields
	logic signed [ppt_pkg::POS_W-1:0]  ref_x, ref_y, pose_x, pose_y;
	logic signed [ppt_pkg::HEAD_W-1:0] ref_heading, pose_heading;

	// results from the output register
	logic signed [ppt_pkg::POS_W-1:0]  out_x, out_y;
	logic signed [ppt_pkg::HEAD_W-1:0] out_heading;

	// links along the cell row: link 0 from the front, link NI into the output stage
	ppt_pkg::ppt_rot_t rot_data  [NI+1];
	logic              rot_valid [NI+1];
	logic              rot_ready [NI+1];

	assign ref_x        = $signed(s_tdata[31:0]);
	assign ref_y        = $signed(s_tdata[63:32]);
	assign ref_heading  = $signed(s_tdata[85:64]);
	assign pose_x       = $signed(s_tdata[117:86]);
	assign pose_y       = $signed(s_tdata[149:118]);
	assign pose_heading = $signed(s_tdata[171:150]);

	// operand set-up, angle reduction to (-pi, pi], fold and gain prescale
	ppt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.command      (s_tuser[0]),
		.ref_x        (ref_x),
		.ref_y        (ref_y),
		.ref_heading  (ref_heading),
		.pose_x       (pose_x),
		.pose_y       (pose_y),
		.pose_heading (pose_heading),
		.out_valid    (rot_valid[0]),
		.out_ready    (rot_ready[0]),
		.out_data     (rot_data[0])
	);

	// one micro-rotation per cell, cell g shifts by g
	for (genvar g = 0; g < NI; g++) begin : g_cell
		ppt_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (ppt_pkg::STEP_W'(g)),
			.in_valid  (rot_valid[g]),
			.in_ready  (rot_ready[g]),
			.in_data   (rot_data[g]),
			.out_valid (rot_valid[g+1]),
			.out_ready (rot_ready[g+1]),
			.out_data  (rot_data[g+1])
		);
	end

	// rounding, frame offset and saturation into the output register
	ppt_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (rot_valid[NI]),
		.in_ready    (rot_ready[NI]),
		.in_data     (rot_data[NI]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_heading (out_heading)
	);

	assign m_tdata = {{ppt_pkg::M_PAD_W{1'b0}}, out_heading, out_y, out_x};

endmodule

FILE: hdl/ppt_front.sv
// front stages: operand set-up, angle reduction, quadrant fold and gain prescale
`include "assert_macros.svh"
module ppt_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic signed [ppt_pkg::POS_W-1:0]    ref_x,
	input  logic signed [ppt_pkg::POS_W-1:0]    ref_y,
	input  logic signed [ppt_pkg::HEAD_W-1:0]   ref_heading,
	input  logic signed [ppt_pkg::POS_W-1:0]    pose_x,
	input  logic signed [ppt_pkg::POS_W-1:0]    pose_y,
	input  logic signed [ppt_pkg::HEAD_W-1:0]   pose_heading,
	output logic                                out_valid,
	input  logic                                out_ready,
	output ppt_pkg::ppt_rot_t                   out_data
);

	// rough turn count, within half a turn of the true one
	function automatic logic signed [ppt_pkg::K_W-1:0] turns_est(
		input logic signed [ppt_pkg::ANG_W-1:0] a
	);
		logic signed [ppt_pkg::KP_W-1:0] p;
		p = a * ppt_pkg::K_MUL + ppt_pkg::K_ROUND;
		turns_est = ppt_pkg::K_W'(p >>> ppt_pkg::K_SHIFT);
	endfunction

	// q.30 residual after taking k whole turns off
	function automatic logic signed [ppt_pkg::RAW_W-1:0] residual(
		input logic signed [ppt_pkg::ANG_W-1:0] a,
		input logic signed [ppt_pkg::K_W-1:0]   k
	);
		logic signed [ppt_pkg::RAW_W-1:0] aw;
		logic signed [ppt_pkg::RAW_W-1:0] kw;
		aw = ppt_pkg::RAW_W'(a) <<< ppt_pkg::ANG_SHIFT;
		kw = ppt_pkg::RAW_W'(k);
		residual = aw - kw * ppt_pkg::TWO_PI_RAW;
	endfunction

	// one correction into (-pi, pi]
	function automatic logic signed [ppt_pkg::ZW-1:0] wrap_fix(
		input logic signed [ppt_pkg::RAW_W-1:0] r
	);
		logic signed [ppt_pkg::RAW_W-1:0] t;
		if (r > ppt_pkg::PI_RAW) begin
			t = r - ppt_pkg::TWO_PI_RAW;
		end else if (r <= -ppt_pkg::PI_RAW) begin
			t = r + ppt_pkg::TWO_PI_RAW;
		end else begin
			t = r;
		end
		wrap_fix = ppt_pkg::ZW'(t);
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	// stage 1 set-up
	logic signed [ppt_pkg::ANG_W-1:0]  rh_w, ph_w, hsum_c, ang_c, dh_c;
	logic signed [ppt_pkg::VEC_W-1:0]  vx_c, vy_c;
	logic signed [ppt_pkg::HEAD_W-1:0] hsat_c;

	logic                              cmd_s1, cmd_s2;
	logic signed [ppt_pkg::VEC_W-1:0]  vx_s1, vy_s1, vx_s2, vy_s2, vx_s3, vy_s3;
	logic signed [ppt_pkg::ANG_W-1:0]  ang_s1, dh_s1;
	logic signed [ppt_pkg::K_W-1:0]    kz_s1, kh_s1;
	logic signed [ppt_pkg::HEAD_W-1:0] hsat_s1, hsat_s2, head_s3, head_s4, head_s5;
	logic signed [ppt_pkg::POS_W-1:0]  rx_s1, ry_s1, rx_s2, ry_s2, rx_s3, ry_s3;
	logic signed [ppt_pkg::POS_W-1:0]  rx_s4, ry_s4, rx_s5, ry_s5;
	logic signed [ppt_pkg::RAW_W-1:0]  rz_s2, rh_s2;
	logic signed [ppt_pkg::ZW-1:0]     z_s3, hd_c, hrnd_c, z_s4, z4_c, z_s5;
	logic                              neg_c, neg_s4;
	logic signed [ppt_pkg::PROD_W-1:0] px_s4, py_s4, pxm_c, pym_c;
	logic signed [ppt_pkg::CW-1:0]     cx_c, cy_c, cx_s5, cy_s5;

	assign rdy_s5   = !vld_s5 || out_ready;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		rh_w   = ppt_pkg::ANG_W'(ref_heading);
		ph_w   = ppt_pkg::ANG_W'(pose_heading);
		hsum_c = rh_w + ph_w;
		dh_c   = ph_w - rh_w;
		if (hsum_c > ppt_pkg::ANG_W'(ppt_pkg::HEAD_MAX)) begin
			hsat_c = ppt_pkg::HEAD_MAX;
		end else if (hsum_c < ppt_pkg::ANG_W'(ppt_pkg::HEAD_MIN)) begin
			hsat_c = ppt_pkg::HEAD_MIN;
		end else begin
			hsat_c = ppt_pkg::HEAD_W'(hsum_c);
		end
		if (command) begin
			// relative: offset from the frame origin, turned back by its heading
			vx_c  = ppt_pkg::VEC_W'(pose_x) - ppt_pkg::VEC_W'(ref_x);
			vy_c  = ppt_pkg::VEC_W'(pose_y) - ppt_pkg::VEC_W'(ref_y);
			ang_c = -rh_w;
		end else begin
			vx_c  = ppt_pkg::VEC_W'(pose_x);
			vy_c  = ppt_pkg::VEC_W'(pose_y);
			ang_c = rh_w;
		end
	end

	// stage 3 heading and stage 4 fold
	always_comb begin
		hd_c   = wrap_fix(rh_s2);
		hrnd_c = (hd_c + ppt_pkg::HEAD_RND) >>> ppt_pkg::ANG_SHIFT;
		neg_c  = 1'b0;
		z4_c   = z_s3;
		if (z_s3 > ppt_pkg::HALF_PI_Z) begin
			neg_c = 1'b1;
			z4_c  = z_s3 - ppt_pkg::PI_Z;
		end else if (z_s3 < -ppt_pkg::HALF_PI_Z) begin
			neg_c = 1'b1;
			z4_c  = z_s3 + ppt_pkg::PI_Z;
		end
	end

	// stage 5: floor shift of the prescaled vector, negated via floor(-p) = ~floor(p - 1)
	always_comb begin
		pxm_c = (px_s4 - ppt_pkg::PROD_W'(1)) >>> ppt_pkg::PRESHIFT;
		pym_c = (py_s4 - ppt_pkg::PROD_W'(1)) >>> ppt_pkg::PRESHIFT;
		if (neg_s4) begin
			cx_c = ~ppt_pkg::CW'(pxm_c);
			cy_c = ~ppt_pkg::CW'(pym_c);
		end else begin
			cx_c = ppt_pkg::CW'(px_s4 >>> ppt_pkg::PRESHIFT);
			cy_c = ppt_pkg::CW'(py_s4 >>> ppt_pkg::PRESHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			cmd_s1  <= command;
			vx_s1   <= vx_c;
			vy_s1   <= vy_c;
			ang_s1  <= ang_c;
			kz_s1   <= turns_est(ang_c);
			dh_s1   <= dh_c;
			kh_s1   <= turns_est(dh_c);
			hsat_s1 <= hsat_c;
			rx_s1   <= command ? '0 : ref_x;
			ry_s1   <= command ? '0 : ref_y;
		end
		if (vld_s1 && rdy_s2) begin
			cmd_s2  <= cmd_s1;
			vx_s2   <= vx_s1;
			vy_s2   <= vy_s1;
			rz_s2   <= residual(ang_s1, kz_s1);
			rh_s2   <= residual(dh_s1, kh_s1);
			hsat_s2 <= hsat_s1;
			rx_s2   <= rx_s1;
			ry_s2   <= ry_s1;
		end
		if (vld_s2 && rdy_s3) begin
			vx_s3   <= vx_s2;
			vy_s3   <= vy_s2;
			z_s3    <= wrap_fix(rz_s2);
			head_s3 <= cmd_s2 ? ppt_pkg::HEAD_W'(hrnd_c) : hsat_s2;
			rx_s3   <= rx_s2;
			ry_s3   <= ry_s2;
		end
		if (vld_s3 && rdy_s4) begin
			px_s4   <= vx_s3 * ppt_pkg::GAIN_Q30;
			py_s4   <= vy_s3 * ppt_pkg::GAIN_Q30;
			neg_s4  <= neg_c;
			z_s4    <= z4_c;
			head_s4 <= head_s3;
			rx_s4   <= rx_s3;
			ry_s4   <= ry_s3;
		end
		if (vld_s4 && rdy_s5) begin
			cx_s5   <= cx_c;
			cy_s5   <= cy_c;
			z_s5    <= z_s4;
			head_s5 <= head_s4;
			rx_s5   <= rx_s4;
			ry_s5   <= ry_s4;
		end
	end

	assign out_valid        = vld_s5;
	assign out_data.cx      = cx_s5;
	assign out_data.cy      = cy_s5;
	assign out_data.z       = z_s5;
	assign out_data.ref_x   = rx_s5;
	assign out_data.ref_y   = ry_s5;
	assign out_data.heading = head_s5;

	`PPT_ASSERT_IMP(a_wrap_range, vld_s3, (z_s3 > -ppt_pkg::PI_Z) && (z_s3 <= ppt_pkg::PI_Z), "rotator angle left (-pi, pi] after reduction")
	`PPT_ASSERT_IMP(a_fold_range, vld_s4, (z_s4 >= -ppt_pkg::HALF_PI_Z) && (z_s4 <= ppt_pkg::HALF_PI_Z), "rotator angle outside the right half plane after fold")
	`PPT_ASSERT_IMP(a_rel_heading, vld_s3 && $past(cmd_s2) && $past(vld_s2 && rdy_s3), (head_s3 >= -ppt_pkg::HEAD_REL_MAX) && (head_s3 <= ppt_pkg::HEAD_REL_MAX), "relative heading not wrapped")

endmodule

FILE: hdl/ppt_cordic_cell.sv
// one rotation cell of the cordic row: a shift-add micro-rotation and its stage register
module ppt_cordic_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  ppt_pkg::step_t     step,
	input  logic               in_valid,
	output logic               in_ready,
	input  ppt_pkg::ppt_rot_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ppt_pkg::ppt_rot_t  out_data
);

	logic                          vld_q;
	ppt_pkg::ppt_rot_t             data_q;
	ppt_pkg::ppt_rot_t             nxt_c;
	logic signed [ppt_pkg::CW-1:0] dx_c, dy_c;
	logic signed [ppt_pkg::ZW-1:0] at_c;

	assign in_ready = !vld_q || out_ready;

	always_comb begin
		nxt_c = in_data;
		dx_c  = in_data.cy >>> step;
		dy_c  = in_data.cx >>> step;
		at_c  = ppt_pkg::atan_q30(step);
		if (!in_data.z[ppt_pkg::ZW-1]) begin
			nxt_c.cx = in_data.cx - dx_c;
			nxt_c.cy = in_data.cy + dy_c;
			nxt_c.z  = in_data.z - at_c;
		end else begin
			nxt_c.cx = in_data.cx + dx_c;
			nxt_c.cy = in_data.cy - dy_c;
			nxt_c.z  = in_data.z + at_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt_c;
		end
	end

	assign out_valid = vld_q;
	assign out_data  = data_q;

endmodule

FILE: hdl/ppt_out.sv
// output register: rounding off the guard bits, frame offset and saturation
`include "assert_macros.svh"
module ppt_out (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  ppt_pkg::ppt_rot_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ppt_pkg::POS_W-1:0]  out_x,
	output logic signed [ppt_pkg::POS_W-1:0]  out_y,
	output logic signed [ppt_pkg::HEAD_W-1:0] out_heading
);

	localparam int SUM_W = ppt_pkg::CW + 1;

	function automatic logic signed [ppt_pkg::POS_W-1:0] finish(
		input logic signed [ppt_pkg::CW-1:0]    c,
		input logic signed [ppt_pkg::POS_W-1:0] r
	);
		logic signed [SUM_W-1:0] s;
		s = (SUM_W'(c) + (SUM_W'(r) <<< ppt_pkg::GUARD)
			+ (SUM_W'(1) <<< (ppt_pkg::GUARD - 1))) >>> ppt_pkg::GUARD;
		if (s > SUM_W'(ppt_pkg::POS_MAX)) begin
			finish = ppt_pkg::POS_MAX;
		end else if (s < SUM_W'(ppt_pkg::POS_MIN)) begin
			finish = ppt_pkg::POS_MIN;
		end else begin
			finish = ppt_pkg::POS_W'(s);
		end
	endfunction

	logic vld_q;

	assign in_ready  = !vld_q || out_ready;
	assign out_valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			out_x       <= finish(in_data.cx, in_data.ref_x);
			out_y       <= finish(in_data.cy, in_data.ref_y);
			out_heading <= in_data.heading;
		end
	end

	`PPT_ASSERT_NXT(a_drain, vld_q && out_ready && !in_valid, !vld_q, "result repeated after its transaction")

endmodule
